// ----- rtl/swee_pkg.sv -----
// Shared types and constants for the sliding window epoch extractor.
package swee_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL      = 2'd2;

    localparam logic [6:0]  RESET_CHANNELS  = 7'd1;
    localparam logic [15:0] RESET_WINDOW    = 16'd256;
    localparam logic [25:0] RESET_INTERVAL  = 26'd256000;

    localparam int QUOT_W = 17;
    localparam int REM_W  = 10;

    localparam logic [QUOT_W-1:0] RESET_INT_QUOT = 17'd256;
    localparam logic [REM_W-1:0]  RESET_INT_REM  = 10'd0;

    localparam int MILLI = 1000;

    // floor(2^32 / 1000); quotient estimate is exact or one low for 26-bit inputs
    localparam int RECIP_W = 23;
    localparam logic [RECIP_W-1:0] RECIP_MILLI = 23'd4294967;
    localparam int PROD_W  = CFG_DATA_W + RECIP_W;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                 ready;
        logic [QUOT_W-1:0]    quot;
        logic [REM_W-1:0]     rem;
    } intv_t;

    typedef struct packed {
        logic first;
        logic last;
    } item_flags_t;

    typedef enum logic {
        BK_LOAD,
        BK_EMIT
    } back_state_t;

endpackage

// ----- rtl/swee_front.sv -----
// Front end: request intake, channel and frame counting, classification.
module swee_front #(
    parameter int MAX_CHANNELS = 64,
    parameter int VAL_W        = 32,
    parameter int SAMPLE_WIDTH = 32,
    parameter int SLOT_W       = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [swee_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swee_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [SAMPLE_WIDTH-1:0]            sample_word,
    input  logic                               q_full,
    output logic                               push,
    output logic [VAL_W-1:0]                   push_value,
    output logic [SLOT_W-1:0]                  push_slot,
    output logic [31:0]                        push_frame,
    output swee_pkg::item_flags_t              push_flags
);

    localparam logic [9:0] CH_MAX = 10'(MAX_CHANNELS);

    logic [6:0]        chan_count_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [31:0]       frame_reg;
    logic [31:0]       frame_next;
    logic [9:0]        chans_eff;
    logic [9:0]        slot_inc;
    logic              last_chan;

    always_comb
    begin
        if (chan_count_reg == 7'd0)
        begin
            chans_eff = 10'd1;
        end
        else if (10'(chan_count_reg) > CH_MAX)
        begin
            chans_eff = CH_MAX;
        end
        else
        begin
            chans_eff = 10'(chan_count_reg);
        end
        slot_inc  = 10'(slot_reg) + 10'd1;
        last_chan = (slot_inc >= chans_eff);
    end

    assign in_stall   = q_full;
    assign push       = in_valid && !q_full;
    assign push_value = sample_word[VAL_W-1:0];
    assign push_slot  = slot_reg;
    assign push_frame = frame_reg;
    assign push_flags = '{first: (slot_reg == '0), last: last_chan};

    always_comb
    begin
        slot_next  = slot_reg;
        frame_next = frame_reg;
        if (push)
        begin
            if (last_chan)
            begin
                slot_next  = '0;
                frame_next = frame_reg + 32'd1;
            end
            else
            begin
                slot_next = slot_inc[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= swee_pkg::RESET_CHANNELS;
            slot_reg       <= '0;
            frame_reg      <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == swee_pkg::CFG_CHANNEL_COUNT)
            begin
                chan_count_reg <= cfg_data[6:0];
            end
            slot_reg  <= slot_next;
            frame_reg <= frame_next;
        end
    end

endmodule

// ----- rtl/swee_queue.sv -----
// Small request queue between front end and epoch engine.
module swee_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign dout  = data_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[tail_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/swee_interval.sv -----
// Interval register split into whole samples and thousandths, by reciprocal multiply.
module swee_interval (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swee_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swee_pkg::CFG_DATA_W-1:0]  cfg_data,
    output swee_pkg::intv_t                  intv
);

    localparam int QW = swee_pkg::QUOT_W;
    localparam int RW = swee_pkg::REM_W;
    localparam int DW = swee_pkg::CFG_DATA_W;
    localparam int PW = swee_pkg::PROD_W;

    logic [DW-1:0] x_reg;
    logic [PW-1:0] prod_reg;
    logic [QW-1:0] q0_reg;
    logic [RW:0]   r0_reg;
    logic [QW-1:0] quot_reg;
    logic [RW-1:0] rem_reg;
    logic [3:0]    stage_reg;
    logic          start;
    logic [DW-1:0] x_clamped;

    assign start     = cfg_we && (cfg_index == swee_pkg::CFG_INTERVAL);
    assign x_clamped = (cfg_data < DW'(swee_pkg::MILLI)) ? DW'(swee_pkg::MILLI) : cfg_data;
    assign intv      = '{ready: (stage_reg == '0), quot: quot_reg, rem: rem_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_clamped;
        end
        if (stage_reg[0])
        begin
            prod_reg <= PW'(x_reg) * PW'(swee_pkg::RECIP_MILLI);
        end
        if (stage_reg[1])
        begin
            q0_reg <= prod_reg[PW-1:32];
        end
        if (stage_reg[2])
        begin
            r0_reg <= (RW+1)'(27'(x_reg) - 27'(q0_reg) * 27'(swee_pkg::MILLI));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            quot_reg  <= swee_pkg::RESET_INT_QUOT;
            rem_reg   <= swee_pkg::RESET_INT_REM;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], start};
            if (stage_reg[3])
            begin
                // correct the estimate, at most one low
                if (r0_reg >= (RW+1)'(swee_pkg::MILLI))
                begin
                    quot_reg <= q0_reg + QW'(1);
                    rem_reg  <= RW'(r0_reg - (RW+1)'(swee_pkg::MILLI));
                end
                else
                begin
                    quot_reg <= q0_reg;
                    rem_reg  <= r0_reg[RW-1:0];
                end
            end
        end
    end

endmodule

// ----- rtl/swee_back.sv -----
// Epoch engine: start accumulator, open-epoch table and result emitter.
module swee_back #(
    parameter int MAX_OPEN     = 8,
    parameter int MAX_WINDOW   = 65535,
    parameter int VAL_W        = 32,
    parameter int SAMPLE_WIDTH = 32,
    parameter int SLOT_W       = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swee_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swee_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  swee_pkg::intv_t                  intv,
    input  logic                             q_empty,
    input  logic [VAL_W-1:0]                 q_value,
    input  logic [SLOT_W-1:0]                q_slot,
    input  logic [31:0]                      q_frame,
    input  swee_pkg::item_flags_t            q_flags,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [31:0]                      epoch_number,
    output logic [31:0]                      epoch_start,
    output logic [15:0]                      position,
    output logic [5:0]                       channel_id,
    output logic [SAMPLE_WIDTH-1:0]          value_out,
    output logic                             epoch_done,
    output logic                             overflow_seen,
    output logic                             last_of_run
);

    localparam int OPEN_W = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
    localparam logic [31:0] WIN_MAX = 32'(MAX_WINDOW);
    localparam int RW = swee_pkg::REM_W;

    swee_pkg::back_state_t state_reg;
    swee_pkg::back_state_t state_next;

    logic [15:0]         window_reg;
    logic [31:0]         win_eff;

    logic [31:0]         open_start_reg  [MAX_OPEN];
    logic [31:0]         open_number_reg [MAX_OPEN];
    logic [MAX_OPEN-1:0] valid_reg;
    logic [MAX_OPEN-1:0] valid_next;
    logic [MAX_OPEN-1:0] mask_reg;
    logic [MAX_OPEN-1:0] mask_next;

    logic [31:0]         next_start_reg;
    logic [RW-1:0]       start_rem_reg;
    logic [31:0]         epochs_reg;
    logic                overflow_reg;

    logic [VAL_W-1:0]    work_value_reg;
    logic [SLOT_W-1:0]   work_slot_reg;
    logic [31:0]         work_frame_reg;
    logic                work_last_reg;

    logic                out_valid_reg;
    logic [31:0]         out_number_reg;
    logic [31:0]         out_start_reg;
    logic [15:0]         out_pos_reg;
    logic [5:0]          out_chan_reg;
    logic [VAL_W-1:0]    out_value_reg;
    logic                out_done_reg;
    logic                out_ovf_reg;
    logic                out_last_reg;

    logic                start_now;
    logic                any_free;
    logic [MAX_OPEN-1:0] free_onehot;
    logic [MAX_OPEN-1:0] keep;
    logic [MAX_OPEN-1:0] new_slot;
    logic [RW:0]         rem_sum;
    logic                carry;

    logic                emit;
    logic                sel_found;
    logic [OPEN_W-1:0]   sel_idx;
    logic [MAX_OPEN-1:0] sel_onehot;
    logic [MAX_OPEN-1:0] rest;
    logic [31:0]         pos_sel;
    logic                done_sel;

    always_comb
    begin
        if (window_reg == 16'd0)
        begin
            win_eff = 32'd1;
        end
        else if (32'(window_reg) > WIN_MAX)
        begin
            win_eff = WIN_MAX;
        end
        else
        begin
            win_eff = 32'(window_reg);
        end
    end

    always_comb
    begin
        start_now   = q_flags.first && (next_start_reg == q_frame);
        free_onehot = '0;
        any_free    = 1'b0;
        for (int s = 0; s < MAX_OPEN; s++)
        begin
            if (!valid_reg[s] && !any_free)
            begin
                free_onehot[s] = 1'b1;
                any_free       = 1'b1;
            end
        end
        for (int s = 0; s < MAX_OPEN; s++)
        begin
            keep[s] = valid_reg[s] && ((q_frame - open_start_reg[s]) < win_eff);
        end
        new_slot = start_now ? free_onehot : '0;
        rem_sum  = (RW+1)'(start_rem_reg) + (RW+1)'(intv.rem);
        carry    = (rem_sum >= (RW+1)'(swee_pkg::MILLI));
    end

    always_comb
    begin
        sel_found  = 1'b0;
        sel_idx    = '0;
        sel_onehot = '0;
        for (int s = 0; s < MAX_OPEN; s++)
        begin
            if (mask_reg[s] && !sel_found)
            begin
                sel_found     = 1'b1;
                sel_idx       = OPEN_W'(s);
                sel_onehot[s] = 1'b1;
            end
        end
        rest     = mask_reg & ~sel_onehot;
        pos_sel  = work_frame_reg - open_start_reg[sel_idx];
        done_sel = (pos_sel == (win_eff - 32'd1)) && work_last_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        mask_next  = mask_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            swee_pkg::BK_LOAD:
            begin
                if (!q_empty && intv.ready)
                begin
                    pop        = 1'b1;
                    valid_next = keep | new_slot;
                    mask_next  = keep | new_slot;
                    if ((keep | new_slot) != '0)
                    begin
                        state_next = swee_pkg::BK_EMIT;
                    end
                end
            end
            swee_pkg::BK_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    emit      = 1'b1;
                    mask_next = rest;
                    if (done_sel)
                    begin
                        valid_next = valid_reg & ~sel_onehot;
                    end
                    if (rest == '0)
                    begin
                        state_next = swee_pkg::BK_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = swee_pkg::BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= swee_pkg::BK_LOAD;
            window_reg     <= swee_pkg::RESET_WINDOW;
            valid_reg      <= '0;
            mask_reg       <= '0;
            next_start_reg <= '0;
            start_rem_reg  <= '0;
            epochs_reg     <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            mask_reg  <= mask_next;
            if (cfg_we && cfg_index == swee_pkg::CFG_WINDOW_LEN)
            begin
                window_reg <= cfg_data[15:0];
            end
            if (pop && start_now)
            begin
                epochs_reg     <= epochs_reg + 32'd1;
                next_start_reg <= next_start_reg + 32'(intv.quot) + 32'(carry);
                start_rem_reg  <= carry ? RW'(rem_sum - (RW+1)'(swee_pkg::MILLI))
                                        : rem_sum[RW-1:0];
                if (!any_free)
                begin
                    overflow_reg <= 1'b1;
                end
            end
            out_valid_reg <= emit || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < MAX_OPEN; s++)
        begin
            if (pop && new_slot[s])
            begin
                open_start_reg[s]  <= q_frame;
                open_number_reg[s] <= epochs_reg;
            end
        end
        if (pop)
        begin
            work_value_reg <= q_value;
            work_slot_reg  <= q_slot;
            work_frame_reg <= q_frame;
            work_last_reg  <= q_flags.last;
        end
        if (emit)
        begin
            out_number_reg <= open_number_reg[sel_idx];
            out_start_reg  <= open_start_reg[sel_idx];
            out_pos_reg    <= pos_sel[15:0];
            out_chan_reg   <= 6'(work_slot_reg);
            out_value_reg  <= work_value_reg;
            out_done_reg   <= done_sel;
            out_ovf_reg    <= overflow_reg;
            out_last_reg   <= (rest == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign epoch_number  = out_number_reg;
    assign epoch_start   = out_start_reg;
    assign position      = out_pos_reg;
    assign channel_id    = out_chan_reg;
    assign value_out     = SAMPLE_WIDTH'(out_value_reg);
    assign epoch_done    = out_done_reg;
    assign overflow_seen = out_ovf_reg;
    assign last_of_run   = out_last_reg;

endmodule

// ----- rtl/sliding_window_epoch_extractor_core.sv -----
// Top level of the sliding window epoch extractor.
//
//   channel   handshake            carries
//   -------   ------------------   ------------------------------------------
//   in        in_valid / in_stall  sample_word, one channel of a frame
//   out       out_valid/out_stall  epoch_number .. last_of_run, one per epoch and sample
//   cfg       cfg_we               cfg_index, cfg_data, write only
//
// The epoch engine pops a sample, then emits a result for each open epoch that covers it
// (0 to MAX_OPEN), one per cycle from its output register while no stall holds it.
// A QUEUE_DEPTH-deep queue lets the front end take requests while the engine works.
// After a write of the interval register the engine waits for the divide by 1000.
// Reset is asynchronous and leaves the block ready at once: no clearing pass.
// A stall on the output holds the result register; the queue absorbs input meanwhile.
module sliding_window_epoch_extractor_core #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_OPEN     = 8,
    parameter int MAX_WINDOW   = 65535,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swee_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swee_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [SAMPLE_WIDTH-1:0]          sample_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [31:0]                      epoch_number,
    output logic [31:0]                      epoch_start,
    output logic [15:0]                      position,
    output logic [5:0]                       channel_id,
    output logic [SAMPLE_WIDTH-1:0]          value_out,
    output logic                             epoch_done,
    output logic                             overflow_seen,
    output logic                             last_of_run
);

    localparam int VAL_W  = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
    localparam int SLOT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int QW     = VAL_W + SLOT_W + 32 + $bits(swee_pkg::item_flags_t);

    logic                  push;
    logic [VAL_W-1:0]      push_value;
    logic [SLOT_W-1:0]     push_slot;
    logic [31:0]           push_frame;
    swee_pkg::item_flags_t push_flags;
    logic                  q_full;
    logic                  q_empty;
    logic                  pop;
    logic [QW-1:0]         q_din;
    logic [QW-1:0]         q_dout;
    logic [VAL_W-1:0]      q_value;
    logic [SLOT_W-1:0]     q_slot;
    logic [31:0]           q_frame;
    swee_pkg::item_flags_t q_flags;
    swee_pkg::intv_t       intv;

    assign q_din = {push_value, push_slot, push_frame, push_flags};
    assign {q_value, q_slot, q_frame, q_flags} = q_dout;

    swee_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .VAL_W        (VAL_W),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SLOT_W       (SLOT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_word (sample_word),
        .q_full      (q_full),
        .push        (push),
        .push_value  (push_value),
        .push_slot   (push_slot),
        .push_frame  (push_frame),
        .push_flags  (push_flags)
    );

    swee_queue #(
        .WIDTH (QW),
        .DEPTH (swee_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .full  (q_full),
        .pop   (pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    swee_interval u_interval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .intv      (intv)
    );

    swee_back #(
        .MAX_OPEN     (MAX_OPEN),
        .MAX_WINDOW   (MAX_WINDOW),
        .VAL_W        (VAL_W),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SLOT_W       (SLOT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .intv          (intv),
        .q_empty       (q_empty),
        .q_value       (q_value),
        .q_slot        (q_slot),
        .q_frame       (q_frame),
        .q_flags       (q_flags),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .epoch_number  (epoch_number),
        .epoch_start   (epoch_start),
        .position      (position),
        .channel_id    (channel_id),
        .value_out     (value_out),
        .epoch_done    (epoch_done),
        .overflow_seen (overflow_seen),
        .last_of_run   (last_of_run)
    );

endmodule

// ----- rtl/swee_checker.sv -----
// Port-level assertions for the epoch extractor, bound to the top level.
module swee_checker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [31:0]             epoch_number,
    input logic [31:0]             epoch_start,
    input logic [15:0]             position,
    input logic [5:0]              channel_id,
    input logic [SAMPLE_WIDTH-1:0] value_out,
    input logic                    overflow_seen,
    input logic                    last_of_run
);

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(epoch_number)
            && $stable(epoch_start) && $stable(position) && $stable(value_out);
    endproperty

    property p_run_continues;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid;
    endproperty

    property p_run_same_sample;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=>
            channel_id == $past(channel_id) && value_out == $past(value_out);
    endproperty

    property p_overflow_sticky;
        @(posedge clk) disable iff (!rst_n)
        out_valid && overflow_seen |=> !out_valid || overflow_seen;
    endproperty

    a_stall_hold:      assert property (p_stall_hold)      else $error("result changed under stall");
    a_run_continues:   assert property (p_run_continues)   else $error("gap inside a result run");
    a_run_same_sample: assert property (p_run_same_sample) else $error("run mixes samples");
    a_overflow_sticky: assert property (p_overflow_sticky) else $error("overflow flag dropped");

endmodule

bind sliding_window_epoch_extractor_core swee_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swee_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_number  (epoch_number),
    .epoch_start   (epoch_start),
    .position      (position),
    .channel_id    (channel_id),
    .value_out     (value_out),
    .overflow_seen (overflow_seen),
    .last_of_run   (last_of_run)
);
